// ===== sv/sliding_window_median_core_defines.svh =====
// ----------------------------------------------------------------------------
// Sliding window median core assertion macros
// Shared concurrent assertion forms for the checker of the median core.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_CORE_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_CORE_DEFINES_SVH

// Property checked on every clock edge, ignored while reset is asserted.
`define SWM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sliding window median check failed");

// Property checked on every clock edge, reset included.
`define SWM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sliding window median reset check failed");

`endif

// ===== sv/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding window median package
// Register map, configuration widths and the cell control type.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int CFG_W  = 7;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 7'd3;

  // Register index taken from the word address bits of paddr.
  localparam logic [ADDR_W-3:0] REG_WINDOW_SIZE = 1'b0;

  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctrl_t;

endpackage

// ===== sv/swm_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted chain cell
// Holds one sample of the sorted window and shifts with its neighbours on
// insertion and eviction.
// ----------------------------------------------------------------------------
module swm_cell #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  swm_pkg::cell_ctrl_t            ctrl,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic signed [SAMPLE_WIDTH-1:0] evict_val,
  input  logic signed [SAMPLE_WIDTH-1:0] left_val,
  input  logic                           left_ins,
  input  logic signed [SAMPLE_WIDTH-1:0] right_val,
  input  logic                           valid,
  output logic signed [SAMPLE_WIDTH-1:0] val,
  output logic                           ins
);

  // The new sample goes in after every held value that is not greater.
  assign ins = !valid || (val > sample);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (left_ins) begin
        val <= left_val;
      end else if (ins) begin
        val <= sample;
      end
    end else if (ctrl.del) begin
      if (valid && (val >= evict_val)) begin
        val <= right_val;
      end
    end
  end

endmodule

// ===== sv/swm_ring.sv =====
// ----------------------------------------------------------------------------
// Arrival ring
// Samples in arrival order, one write port and one registered read port.
// ----------------------------------------------------------------------------
module swm_ring #(
  parameter int AW = 6,
  parameter int W  = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/sliding_window_median_core.sv =====
// ----------------------------------------------------------------------------
// Sliding window median core
// Keeps the latest window of samples in a sorted chain of cells and gives
// twice the median for every sample once the window is full.
// ----------------------------------------------------------------------------
// An item that does not fill the window is taken in the idle state.
// An item that fills it is inserted into the cell chain as it is taken, then
// the median is read and the oldest sample evicted in the median state, which
// waits while an earlier result is held; the result is registered from the
// median read. Synchronous reset empties the window and sets the window size
// to 3; the stores hold no reset value and need no clearing.
module sliding_window_median_core #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [SAMPLE_WIDTH-1:0] sample
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [SAMPLE_WIDTH:0] median_twice
  output logic [((SAMPLE_WIDTH+8)/8)*8-1:0] m_axis_tdata,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [swm_pkg::ADDR_W-1:0]       paddr,
  input  logic [swm_pkg::DATA_W-1:0]       pwdata,
  output logic [swm_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);

  localparam int SW      = SAMPLE_WIDTH;
  localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
  localparam int RING_AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int OW      = CNT_W + RING_AW;
  localparam int OUT_TW  = ((SAMPLE_WIDTH + 8) / 8) * 8;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_MED  = 1'b1;

  logic                       state;
  logic [swm_pkg::CFG_W-1:0]  window_size;
  logic [CNT_W-1:0]           fill;
  logic [RING_AW-1:0]         wp;
  logic signed [SW-1:0]       s_hold;
  logic                       out_valid;
  logic [SW:0]                out_data;

  logic [CNT_W-1:0]           k_act;
  logic [CNT_W-1:0]           lo_idx;
  logic [CNT_W-1:0]           hi_idx;
  logic                       accept;
  logic                       cfg_hit;
  logic                       med_fire;
  logic                       fills_window;
  logic signed [SW-1:0]       sample;
  logic [OW-1:0]              oldest_sum;
  logic [SW-1:0]              ring_rd;
  logic signed [SW-1:0]       evict_val;
  logic signed [SW-1:0]       lo_val;
  logic signed [SW-1:0]       hi_val;
  logic [SW:0]                median_sum;
  swm_pkg::cell_ctrl_t        cell_ctrl;

  logic signed [SW-1:0]       cell_val [WINDOW_MAX];
  logic                       cell_ins [WINDOW_MAX];

  assign sample        = s_axis_tdata[SW-1:0];
  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign med_fire      = (state == ST_MED) && (!out_valid || m_axis_tready);
  assign pready        = 1'b1;
  assign cfg_hit       = (paddr[swm_pkg::ADDR_W-1:2] == swm_pkg::REG_WINDOW_SIZE);

  always_comb begin
    if (window_size == '0) begin
      k_act = CNT_W'(1);
    end else if (int'(window_size) > WINDOW_MAX) begin
      k_act = CNT_W'(WINDOW_MAX);
    end else begin
      k_act = CNT_W'(window_size);
    end
  end

  assign lo_idx       = (k_act - CNT_W'(1)) >> 1;
  assign hi_idx       = k_act >> 1;
  assign fills_window = ((fill + CNT_W'(1)) == k_act);

  assign prdata = cfg_hit ? swm_pkg::DATA_W'(window_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      window_size <= swm_pkg::WINDOW_SIZE_RESET;
      fill        <= '0;
      wp          <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && cfg_hit) begin
        window_size <= pwdata[swm_pkg::CFG_W-1:0];
        fill        <= '0;
        wp          <= '0;
      end else if (accept) begin
        fill <= fill + CNT_W'(1);
        wp   <= wp + RING_AW'(1);
      end else if (med_fire) begin
        fill <= fill - CNT_W'(1);
      end

      case (state)
        ST_IDLE: begin
          if (accept && fills_window) begin
            state <= ST_MED;
          end
        end
        ST_MED: begin
          if (med_fire) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (med_fire) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_hold <= sample;
    end
    if (med_fire) begin
      out_data <= median_sum;
    end
  end

  assign oldest_sum = OW'(wp) + OW'(1) - OW'(k_act);

  swm_ring #(
    .AW (RING_AW),
    .W  (SW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (wp),
    .wr_data (sample),
    .rd_en   (accept),
    .rd_addr (oldest_sum[RING_AW-1:0]),
    .rd_data (ring_rd)
  );

  // With a window of one the oldest sample is the one written alongside the read.
  assign evict_val = (k_act == CNT_W'(1)) ? s_hold : $signed(ring_rd);

  assign cell_ctrl.ins = accept;
  assign cell_ctrl.del = med_fire;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic signed [SW-1:0] left_val;
    logic                 left_ins;
    logic signed [SW-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_val = '0;
      assign left_ins = 1'b0;
    end else begin : g_mid
      assign left_val = cell_val[i-1];
      assign left_ins = cell_ins[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_next
      assign right_val = cell_val[i+1];
    end

    swm_cell #(
      .SAMPLE_WIDTH (SW)
    ) u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .sample    (sample),
      .evict_val (evict_val),
      .left_val  (left_val),
      .left_ins  (left_ins),
      .right_val (right_val),
      .valid     (CNT_W'(i) < fill),
      .val       (cell_val[i]),
      .ins       (cell_ins[i])
    );
  end

  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      lo_val = lo_val | (cell_val[i] & {SW{lo_idx == CNT_W'(i)}});
      hi_val = hi_val | (cell_val[i] & {SW{hi_idx == CNT_W'(i)}});
    end
  end

  assign median_sum = {lo_val[SW-1], lo_val} + {hi_val[SW-1], hi_val};

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TW'(out_data);

endmodule

// ===== sv/swm_checker.sv =====
// ----------------------------------------------------------------------------
// Sliding window median port checker
// Watches the ports of the median core for reset, sequencing and output rules.
// ----------------------------------------------------------------------------
`include "sliding_window_median_core_defines.svh"

module swm_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [((SAMPLE_WIDTH+8)/8)*8-1:0] m_axis_tdata
);

  `SWM_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> (!m_axis_tvalid && s_axis_tready))
  `SWM_ASSERT(a_result_after_item, clk, rst, $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
  `SWM_ASSERT(a_busy_while_blocked, clk, rst, (!s_axis_tready && m_axis_tvalid && !m_axis_tready) |=> !s_axis_tready)
  `SWM_ASSERT(a_output_holds, clk, rst, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))

endmodule

bind sliding_window_median_core swm_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swm_checker (.*);
